@@ design/cpms_pkg.sv @@
// ----------------------------------------------------------------------------
// cpms_pkg: shared types and constants of the cylindrical particle motion step
// request codes, register indexes, fixed-point widths and the quarter sine table
// ----------------------------------------------------------------------------
`default_nettype none

package cpms_pkg;

   // angle is cut to this many bits before the sine lookup
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QTAB_LAST       = 2 ** QUARTER_BITS;
   localparam int QTAB_LEN        = QTAB_LAST + 1;
   localparam int QIDX_W          = QUARTER_BITS + 1;
   localparam int QSINE_W         = 17;
   localparam int SINE_W          = QSINE_W + 1;

   localparam int OPCODE_W  = 3;
   localparam int VALUE_W   = 32;
   localparam int POINT_W   = 32;
   localparam int ANGLE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 96;

   // polynomial coefficients, Q16
   localparam logic [63:0] COEF_A = 64'd102944;
   localparam logic [63:0] COEF_B = 64'd42047;
   localparam logic [63:0] COEF_C = 64'd4639;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK             = 3'd0,
      OP_SET_RADIUS       = 3'd1,
      OP_SET_ANGLE        = 3'd2,
      OP_SET_HEIGHT       = 3'd3,
      OP_SET_RADIUS_SPEED = 3'd4,
      OP_SET_ANGLE_SPEED  = 3'd5,
      OP_SET_HEIGHT_SPEED = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_X    = 2'd3
   } axis_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_MODE  = 3'd0,
      CSR_MAX_RADIUS = 3'd1,
      CSR_HEIGHT_MIN = 3'd2,
      CSR_HEIGHT_MAX = 3'd3,
      CSR_OFFSET_X   = 3'd4,
      CSR_OFFSET_Y   = 3'd5,
      CSR_OFFSET_Z   = 3'd6
   } csr_index_type;

   typedef logic [QSINE_W-1:0] qsine_tab_type [QTAB_LEN];

   // quarter-turn sine, x*(A - x2*(B - x2*C)) with floor after each product
   function automatic qsine_tab_type build_qsine();
      qsine_tab_type tab;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   t;
      int            i;
      for (i = 0; i < QTAB_LEN; i++) begin
         x      = 64'(i) << (16 - QUARTER_BITS);
         x2     = (x * x) >> 16;
         t      = (COEF_C * x2) >> 16;
         t      = COEF_B - t;
         t      = (t * x2) >> 16;
         t      = COEF_A - t;
         t      = (t * x) >> 16;
         tab[i] = t[QSINE_W-1:0];
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE_TAB = build_qsine();

endpackage

`default_nettype wire

@@ design/cylindrical_particle_motion_step_unit.sv @@
// ----------------------------------------------------------------------------
// cylindrical_particle_motion_step_unit
// one particle in cylindrical coordinates, stepped and placed per request
// ----------------------------------------------------------------------------
`default_nettype none

// The unit holds one particle (radius, angle, height and their speeds) and
// takes one request per clock: a tick, or a load of a coordinate or a speed.
// Every request returns one response carrying the last computed Cartesian
// point. Particle state is updated at the clock edge that accepts the request,
// so back-to-back ticks see each other's result without stalls; the radius
// reflection, the height clamp and the speed adds form that feedback loop.
// The point itself (sine lookup, radius multiply, offset add) runs in a
// four-deep pipeline behind it: stage 1, 2 and 3 registers, then the response
// register. The whole pipeline advances only while the response register is
// empty or being taken, so rsp_tready low holds back req_tready too.
// Configuration registers are to be written through the csr port only while
// no request is in flight; the block itself does not enforce this.

module cylindrical_particle_motion_step_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [cpms_pkg::REQ_DATA_W-1:0]  req_tdata,  // opcode[2:0], value[34:3]
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [cpms_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // point_x, point_y, point_z
   // configuration write port
   input  wire logic                             csr_we,
   input  wire logic [cpms_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  wire logic [31:0]                      csr_wdata
);

   localparam int SB = cpms_pkg::SINE_TABLE_BITS;
   localparam int SW = cpms_pkg::SINE_W;
   localparam int PW = 32 + SW;                 // radius times sine

   localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

   // ---------------------------------------------------------------- helpers
   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // negate, with the most negative value going to the most positive
   function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == 32'sh80000000) begin
         r = 32'sh7fffffff;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // full-turn sine from the quarter table, Q16
   function automatic logic signed [SW-1:0] sine_lookup(input logic [SB-1:0] idx);
      logic [1:0]                       quad;
      logic [cpms_pkg::QUARTER_BITS-1:0] pos;
      logic [cpms_pkg::QIDX_W-1:0]      tidx;
      logic signed [SW-1:0]             mag;
      quad = idx[SB-1 -: 2];
      pos  = idx[cpms_pkg::QUARTER_BITS-1:0];
      if (quad[0]) begin
         tidx = cpms_pkg::QIDX_W'(cpms_pkg::QTAB_LAST) - {1'b0, pos};
      end else begin
         tidx = {1'b0, pos};
      end
      mag = $signed({1'b0, cpms_pkg::QSINE_TAB[tidx]});
      return quad[1] ? -mag : mag;
   endfunction

   // ---------------------------------------------------------------- config
   cpms_pkg::axis_type axis_mode_ff;
   logic [30:0]        max_radius_ff;
   logic signed [31:0] height_min_ff;
   logic signed [31:0] height_max_ff;
   logic signed [31:0] offset_x_ff;
   logic signed [31:0] offset_y_ff;
   logic signed [31:0] offset_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_mode_ff  <= cpms_pkg::AXIS_Y;
         max_radius_ff <= 31'd65536;
         height_min_ff <= -32'sd65536;
         height_max_ff <= 32'sd65536;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         offset_z_ff   <= '0;
      end else if (csr_we) begin
         case (cpms_pkg::csr_index_type'(csr_addr))
            cpms_pkg::CSR_AXIS_MODE:  axis_mode_ff  <= cpms_pkg::axis_type'(csr_wdata[1:0]);
            cpms_pkg::CSR_MAX_RADIUS: max_radius_ff <= csr_wdata[30:0];
            cpms_pkg::CSR_HEIGHT_MIN: height_min_ff <= csr_wdata;
            cpms_pkg::CSR_HEIGHT_MAX: height_max_ff <= csr_wdata;
            cpms_pkg::CSR_OFFSET_X:   offset_x_ff   <= csr_wdata;
            cpms_pkg::CSR_OFFSET_Y:   offset_y_ff   <= csr_wdata;
            cpms_pkg::CSR_OFFSET_Z:   offset_z_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic pipe_advance;
   logic req_accept;
   logic rsp_valid_ff;

   // the pipeline moves as a whole when the response slot frees up
   assign pipe_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready   = pipe_advance;
   assign req_accept   = req_tvalid && pipe_advance;

   cpms_pkg::opcode_type req_opcode;
   logic signed [31:0]   req_value;

   assign req_opcode = cpms_pkg::opcode_type'(req_tdata[2:0]);
   assign req_value  = req_tdata[34:3];

   // ---------------------------------------------------------------- particle state
   logic signed [31:0]                  radius_ff,       radius_in;
   logic [cpms_pkg::ANGLE_W-1:0]        angle_ff,        angle_in;
   logic signed [31:0]                  height_ff,       height_in;
   logic signed [31:0]                  radius_speed_ff, radius_speed_in;
   logic [cpms_pkg::ANGLE_W-1:0]        angle_speed_ff,  angle_speed_in;
   logic signed [31:0]                  height_speed_ff, height_speed_in;

   // tick path: reflect radius, clamp axis coordinate, add speeds
   logic signed [31:0] max_signed;
   logic               refl_hi;
   logic               refl_lo;
   logic signed [31:0] rad_refl;
   logic signed [31:0] rs_refl;
   logic signed [31:0] axis_off;
   logic signed [31:0] coord_raw;
   logic signed [31:0] coord_hi;
   logic signed [31:0] coord_clamped;
   logic               clamp_hi;
   logic               clamp_lo;
   logic signed [31:0] hs_hi;
   logic signed [31:0] hs_tick;
   logic               form_point;

   always_comb begin
      max_signed = $signed({1'b0, max_radius_ff});
      refl_hi    = radius_ff > max_signed;
      refl_lo    = radius_ff < 0;
      if (refl_hi) begin
         rad_refl = max_signed;
      end else if (refl_lo) begin
         rad_refl = '0;
      end else begin
         rad_refl = radius_ff;
      end
      rs_refl = (refl_hi || refl_lo) ? neg32(radius_speed_ff) : radius_speed_ff;

      form_point = axis_mode_ff != cpms_pkg::AXIS_NONE;
      case (axis_mode_ff)
         cpms_pkg::AXIS_Y: axis_off = offset_y_ff;
         cpms_pkg::AXIS_Z: axis_off = offset_z_ff;
         cpms_pkg::AXIS_X: axis_off = offset_x_ff;
         default:          axis_off = '0;
      endcase

      // upper limit first, then lower; inverted limits end on height_min
      coord_raw     = sat32(35'(height_ff) + 35'(axis_off));
      clamp_hi      = form_point && (coord_raw > height_max_ff);
      coord_hi      = clamp_hi ? height_max_ff : coord_raw;
      clamp_lo      = form_point && (coord_hi < height_min_ff);
      coord_clamped = clamp_lo ? height_min_ff : coord_hi;
      hs_hi         = clamp_hi ? neg32(height_speed_ff) : height_speed_ff;
      hs_tick       = clamp_lo ? neg32(hs_hi) : hs_hi;
   end

   always_comb begin
      radius_in       = radius_ff;
      angle_in        = angle_ff;
      height_in       = height_ff;
      radius_speed_in = radius_speed_ff;
      angle_speed_in  = angle_speed_ff;
      height_speed_in = height_speed_ff;
      if (req_accept) begin
         case (req_opcode)
            cpms_pkg::OP_TICK: begin
               radius_in       = sat32(35'(rad_refl) + 35'(rs_refl));
               radius_speed_in = rs_refl;
               angle_in        = angle_ff + angle_speed_ff;
               height_in       = sat32(35'(height_ff) + 35'(hs_tick));
               height_speed_in = hs_tick;
            end
            cpms_pkg::OP_SET_RADIUS: begin
               radius_in       = (req_value < 0) ? 32'sd0 : req_value;
               radius_speed_in = '0;
            end
            cpms_pkg::OP_SET_ANGLE: begin
               angle_in       = req_value[15:0];
               angle_speed_in = '0;
            end
            cpms_pkg::OP_SET_HEIGHT: begin
               height_in       = req_value;
               height_speed_in = '0;
            end
            cpms_pkg::OP_SET_RADIUS_SPEED: radius_speed_in = req_value;
            cpms_pkg::OP_SET_ANGLE_SPEED:  angle_speed_in  = req_value[15:0];
            cpms_pkg::OP_SET_HEIGHT_SPEED: height_speed_in = req_value;
            default: ;  // unused code: no change
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= '0;
         angle_ff        <= '0;
         height_ff       <= '0;
         radius_speed_ff <= '0;
         angle_speed_ff  <= '0;
         height_speed_ff <= '0;
      end else begin
         radius_ff       <= radius_in;
         angle_ff        <= angle_in;
         height_ff       <= height_in;
         radius_speed_ff <= radius_speed_in;
         angle_speed_ff  <= angle_speed_in;
         height_speed_ff <= height_speed_in;
      end
   end

   // ---------------------------------------------------------------- point pipeline
   // stage 1: reflected radius, table index and clamped axis coordinate
   logic          p1_valid_ff;
   logic          p1_form_ff;
   logic [30:0]   p1_radius_ff;
   logic [SB-1:0] p1_idx_ff;
   logic signed [31:0] p1_coord_ff;

   // stage 2: sine and cosine
   logic          p2_valid_ff;
   logic          p2_form_ff;
   logic [30:0]   p2_radius_ff;
   logic signed [SW-1:0] p2_sin_ff;
   logic signed [SW-1:0] p2_cos_ff;
   logic signed [31:0]   p2_coord_ff;

   // stage 3: radius products
   logic          p3_valid_ff;
   logic          p3_form_ff;
   logic signed [PW-1:0] p3_prod_s_ff;
   logic signed [PW-1:0] p3_prod_c_ff;
   logic signed [31:0]   p3_coord_ff;

   logic [SB-1:0] cos_idx;
   assign cos_idx = p1_idx_ff + SB'(cpms_pkg::QTAB_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p1_form_ff  <= 1'b0;
         p2_valid_ff <= 1'b0;
         p2_form_ff  <= 1'b0;
         p3_valid_ff <= 1'b0;
         p3_form_ff  <= 1'b0;
      end else if (pipe_advance) begin
         p1_valid_ff <= req_tvalid;
         p1_form_ff  <= req_tvalid && (req_opcode == cpms_pkg::OP_TICK) && form_point;
         p2_valid_ff <= p1_valid_ff;
         p2_form_ff  <= p1_form_ff;
         p3_valid_ff <= p2_valid_ff;
         p3_form_ff  <= p2_form_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p1_radius_ff <= rad_refl[30:0];
         p1_idx_ff    <= angle_ff[cpms_pkg::ANGLE_W-1 -: SB];
         p1_coord_ff  <= coord_clamped;
         p2_radius_ff <= p1_radius_ff;
         p2_sin_ff    <= sine_lookup(p1_idx_ff);
         p2_cos_ff    <= sine_lookup(cos_idx);
         p2_coord_ff  <= p1_coord_ff;
         p3_prod_s_ff <= PW'($signed({1'b0, p2_radius_ff}) * p2_sin_ff);
         p3_prod_c_ff <= PW'($signed({1'b0, p2_radius_ff}) * p2_cos_ff);
         p3_coord_ff  <= p2_coord_ff;
      end
   end

   // stage 4: floor, offset and route to the axes
   logic signed [31:0] off_c;
   logic signed [31:0] off_s;
   logic signed [31:0] place_c;
   logic signed [31:0] place_s;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_z;

   always_comb begin
      off_c   = (axis_mode_ff == cpms_pkg::AXIS_X) ? offset_y_ff : offset_x_ff;
      off_s   = (axis_mode_ff == cpms_pkg::AXIS_Z) ? offset_y_ff : offset_z_ff;
      place_c = sat32(35'($signed(p3_prod_c_ff[PW-1:16])) + 35'(off_c));
      place_s = sat32(35'($signed(p3_prod_s_ff[PW-1:16])) + 35'(off_s));
      case (axis_mode_ff)
         cpms_pkg::AXIS_Z: begin
            new_x = place_c;
            new_y = place_s;
            new_z = p3_coord_ff;
         end
         cpms_pkg::AXIS_X: begin
            new_x = p3_coord_ff;
            new_y = place_c;
            new_z = place_s;
         end
         default: begin
            new_x = place_c;
            new_y = p3_coord_ff;
            new_z = place_s;
         end
      endcase
   end

   // response register doubles as the last point
   logic signed [31:0] point_x_ff;
   logic signed [31:0] point_y_ff;
   logic signed [31:0] point_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         point_z_ff   <= '0;
      end else if (pipe_advance) begin
         rsp_valid_ff <= p3_valid_ff;
         if (p3_valid_ff && p3_form_ff) begin
            point_x_ff <= new_x;
            point_y_ff <= new_y;
            point_z_ff <= new_z;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {point_z_ff, point_y_ff, point_x_ff};

`ifndef SYNTHESIS
   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> p1_valid_ff)
      else $error("accepted request missing from first stage");

   a_tick_forms_point: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == cpms_pkg::OP_TICK) && form_point) |=> p1_form_ff)
      else $error("tick did not mark a point update");

   a_set_keeps_point: assert property (@(posedge clock) disable iff (reset)
      (pipe_advance && p3_valid_ff && !p3_form_ff) |=>
         ($stable(point_x_ff) && $stable(point_y_ff) && $stable(point_z_ff)))
      else $error("point changed on a request without a point update");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      p2_form_ff |-> (p2_sin_ff <= 18'sd65536 && p2_sin_ff >= -18'sd65536
                      && p2_cos_ff <= 18'sd65536 && p2_cos_ff >= -18'sd65536))
      else $error("sine out of range");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !pipe_advance |=> ($stable(p3_valid_ff) && $stable(p3_coord_ff)
                         && $stable(p3_prod_s_ff)))
      else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for cylindrical_particle_motion_step_unit
// drives opcode/value requests with random pauses on both channels, predicts
// every point from an in-bench particle model or a directed row, and steps
// the csr settings through extremes, inverted height limits and axis-off mode
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int     STB      = cpms_pkg::SINE_TABLE_BITS;
   localparam longint Q_MAX    = 64'sd2147483647;
   localparam longint Q_MIN    = -64'sd2147483648;
   localparam int     Q_ONE    = 65536;
   // opcode seven is left unused by the block and must be a no-op
   localparam logic [cpms_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;
   // polynomial of the quarter-turn sine, Q16
   localparam longint POLY_A = 102944;
   localparam longint POLY_B = 42047;
   localparam longint POLY_C = 4639;

   // x in [31:0], y in [63:32], z in [95:64], same as rsp_tdata
   typedef logic [2:0][cpms_pkg::POINT_W-1:0] point_vec_type;

   typedef struct {
      logic [cpms_pkg::OPCODE_W-1:0] op;
      logic [cpms_pkg::VALUE_W-1:0]  val;
      bit                            typed;
      point_vec_type                 want;
   } stim_row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cpms_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [cpms_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [cpms_pkg::CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [31:0]                     csr_wdata  = '0;

   // copy of the csr settings
   cpms_pkg::axis_type cfg_axis;
   logic [30:0]        cfg_max_rad;
   logic signed [31:0] cfg_hmin;
   logic signed [31:0] cfg_hmax;
   logic signed [31:0] cfg_off_x;
   logic signed [31:0] cfg_off_y;
   logic signed [31:0] cfg_off_z;

   // particle state as the block should hold it
   logic signed [31:0] rad;
   logic [15:0]        ang;
   logic signed [31:0] hgt;
   logic signed [31:0] rad_vel;
   logic [15:0]        ang_vel;
   logic signed [31:0] hgt_vel;
   point_vec_type      last_pt;

   point_vec_type pending_points [$];
   stim_row_type  stim_rows [$];

   int  error_count    = 0;
   int  requests_sent  = 0;
   int  ticks_sent     = 0;
   int  points_checked = 0;
   int  settings_used  = 0;
   bit  req_burst      = 1'b0;
   bit  rsp_burst      = 1'b0;

   always #2 clock = ~clock;

   cylindrical_particle_motion_step_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // opcode[2:0], value[34:3], zero fill
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // point_x[31:0], point_y[63:32], point_z[95:64]
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // particle model
   // ------------------------------------------------------------------------

   function automatic logic signed [31:0] sat32(longint v);
      if (v > Q_MAX) return Q_MAX[31:0];
      if (v < Q_MIN) return Q_MIN[31:0];
      return v[31:0];
   endfunction

   // negating the most negative speed pins it to the most positive
   function automatic logic signed [31:0] negate_sat(logic signed [31:0] v);
      return sat32(-longint'(v));
   endfunction

   // x in Q16 over one quarter turn, every product floored by 16 bits
   function automatic longint quarter_poly(longint x);
      longint sq;
      longint t;
      sq = (x * x) >>> 16;
      t  = (POLY_C * sq) >>> 16;
      t  = ((POLY_B - t) * sq) >>> 16;
      return ((POLY_A - t) * x) >>> 16;
   endfunction

   // table index has STB bits, top two pick the quadrant
   function automatic longint sine_q16(int unsigned idx);
      int unsigned quad;
      int unsigned pos;
      longint      x;
      longint      y;
      idx  = idx & ((1 << STB) - 1);
      quad = (idx >> (STB - 2)) & 3;
      pos  = idx & ((1 << (STB - 2)) - 1);
      x    = longint'(pos) << (18 - STB);
      if (quad & 1) x = 65536 - x;
      y = quarter_poly(x);
      return (quad & 2) ? -y : y;
   endfunction

   function automatic logic signed [31:0] project(logic signed [31:0] r, longint s,
                                                  logic signed [31:0] off);
      return sat32(((longint'(r) * s) >>> 16) + longint'(off));
   endfunction

   // upper limit tested first; inverted limits end on height_min
   function automatic logic signed [31:0] clamp_height(logic signed [31:0] h,
                                                       logic signed [31:0] off);
      logic signed [31:0] c;
      c = sat32(longint'(h) + longint'(off));
      if (c > cfg_hmax) begin
         c       = cfg_hmax;
         hgt_vel = negate_sat(hgt_vel);
      end
      if (c < cfg_hmin) begin
         c       = cfg_hmin;
         hgt_vel = negate_sat(hgt_vel);
      end
      return c;
   endfunction

   function automatic point_vec_type step_particle(logic [cpms_pkg::OPCODE_W-1:0] op,
                                                   logic [cpms_pkg::VALUE_W-1:0] val);
      int unsigned idx;
      longint      s;
      longint      c;
      case (op)
         cpms_pkg::OP_TICK: begin
            // radius bounces off max_radius and zero
            if (longint'(rad) > longint'(cfg_max_rad)) begin
               rad     = {1'b0, cfg_max_rad};
               rad_vel = negate_sat(rad_vel);
            end
            if (rad < 0) begin
               rad     = '0;
               rad_vel = negate_sat(rad_vel);
            end
            idx = ang >> (16 - STB);
            s   = sine_q16(idx);
            c   = sine_q16(idx + (1 << (STB - 2)));
            case (cfg_axis)
               cpms_pkg::AXIS_Y: begin
                  last_pt[0] = project(rad, c, cfg_off_x);
                  last_pt[1] = clamp_height(hgt, cfg_off_y);
                  last_pt[2] = project(rad, s, cfg_off_z);
               end
               cpms_pkg::AXIS_Z: begin
                  last_pt[0] = project(rad, c, cfg_off_x);
                  last_pt[1] = project(rad, s, cfg_off_y);
                  last_pt[2] = clamp_height(hgt, cfg_off_z);
               end
               cpms_pkg::AXIS_X: begin
                  last_pt[0] = clamp_height(hgt, cfg_off_x);
                  last_pt[1] = project(rad, c, cfg_off_y);
                  last_pt[2] = project(rad, s, cfg_off_z);
               end
               default: ;   // axis off keeps the old point
            endcase
            rad = sat32(longint'(rad) + longint'(rad_vel));
            ang = ang + ang_vel;
            hgt = sat32(longint'(hgt) + longint'(hgt_vel));
         end
         cpms_pkg::OP_SET_RADIUS: begin
            rad_vel = '0;
            rad     = ($signed(val) < 0) ? '0 : val;
         end
         cpms_pkg::OP_SET_ANGLE: begin
            ang_vel = '0;
            ang     = val[15:0];
         end
         cpms_pkg::OP_SET_HEIGHT: begin
            hgt_vel = '0;
            hgt     = val;
         end
         cpms_pkg::OP_SET_RADIUS_SPEED: rad_vel = val;
         cpms_pkg::OP_SET_ANGLE_SPEED:  ang_vel = val[15:0];
         cpms_pkg::OP_SET_HEIGHT_SPEED: hgt_vel = val;
         default: ;
      endcase
      return last_pt;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic int pause_len(bit burst);
      return burst ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic point_vec_type pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      return {z, y, x};
   endfunction

   function automatic void add_row(logic [cpms_pkg::OPCODE_W-1:0] op,
                                   logic [cpms_pkg::VALUE_W-1:0] val,
                                   bit typed = 1'b0, point_vec_type want = '0);
      stim_row_type row;
      row.op    = op;
      row.val   = val;
      row.typed = typed;
      row.want  = want;
      stim_rows.push_back(row);
   endfunction

   // mostly Q16 values near the working range, with extremes and full noise
   function automatic logic [31:0] draw_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return Q_MAX[31:0];
               1: return Q_MIN[31:0];
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2: return $urandom;
         3: return $urandom_range(0, 2 * Q_ONE) - Q_ONE / 8;
         default: return $urandom_range(0, 16 * Q_ONE) - 8 * Q_ONE;
      endcase
   endfunction

   function automatic logic [cpms_pkg::OPCODE_W-1:0] draw_opcode();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return cpms_pkg::OP_TICK;
      if (pick < 96) begin
         return cpms_pkg::OPCODE_W'($urandom_range(cpms_pkg::OP_SET_RADIUS,
                                                   cpms_pkg::OP_SET_HEIGHT_SPEED));
      end
      return OP_UNUSED;
   endfunction

   // one request, held until accepted; the expected point is queued on accept
   task automatic push_request(logic [cpms_pkg::OPCODE_W-1:0] op,
                               logic [cpms_pkg::VALUE_W-1:0] val,
                               bit typed = 1'b0, point_vec_type want = '0);
      int            gap;
      point_vec_type model_pt;
      gap = pause_len(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(cpms_pkg::REQ_DATA_W - cpms_pkg::VALUE_W - cpms_pkg::OPCODE_W){1'b0}},
                     val, op};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      model_pt = step_particle(op, val);
      pending_points.push_back(typed ? want : model_pt);
      requests_sent++;
      if (op == cpms_pkg::OP_TICK) ticks_sent++;
      // swap between paced and back-to-back stretches
      if (requests_sent % 40 == 0) req_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic write_csr(cpms_pkg::csr_index_type idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         cpms_pkg::CSR_AXIS_MODE:  cfg_axis    = cpms_pkg::axis_type'(data[1:0]);
         cpms_pkg::CSR_MAX_RADIUS: cfg_max_rad = data[30:0];
         cpms_pkg::CSR_HEIGHT_MIN: cfg_hmin    = data;
         cpms_pkg::CSR_HEIGHT_MAX: cfg_hmax    = data;
         cpms_pkg::CSR_OFFSET_X:   cfg_off_x   = data;
         cpms_pkg::CSR_OFFSET_Y:   cfg_off_y   = data;
         cpms_pkg::CSR_OFFSET_Z:   cfg_off_z   = data;
         default: ;
      endcase
   endtask

   // waits for the pipeline to drain, then writes every register
   task automatic program_registers(logic [1:0] axis, logic [30:0] max_rad,
                                    logic [31:0] hmin, logic [31:0] hmax,
                                    logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
      logic [31:0] noise;
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      noise = $urandom;
      // unused upper bits carry noise, the block must drop them
      write_csr(cpms_pkg::CSR_AXIS_MODE,  {noise[31:2], axis});
      write_csr(cpms_pkg::CSR_MAX_RADIUS, {noise[31], max_rad});
      write_csr(cpms_pkg::CSR_HEIGHT_MIN, hmin);
      write_csr(cpms_pkg::CSR_HEIGHT_MAX, hmax);
      write_csr(cpms_pkg::CSR_OFFSET_X,   ox);
      write_csr(cpms_pkg::CSR_OFFSET_Y,   oy);
      write_csr(cpms_pkg::CSR_OFFSET_Z,   oz);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(int count);
      for (int n = 0; n < count; n++) push_request(draw_opcode(), draw_value());
   endtask

   function automatic logic [31:0] draw_offset();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
   endfunction

   // ------------------------------------------------------------------------
   // response side: random stalls, then field by field compare
   // ------------------------------------------------------------------------

   initial begin
      int            gap;
      point_vec_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pause_len(rsp_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         if (pending_points.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            for (int f = 0; f < 3; f++) begin
               if (rsp_tdata[f*cpms_pkg::POINT_W +: cpms_pkg::POINT_W] !== want[f]) begin
                  $error("%s mismatch: expected %0d, got %0d",
                         (f == 0) ? "point_x" : (f == 1) ? "point_y" : "point_z",
                         $signed(want[f]),
                         $signed(rsp_tdata[f*cpms_pkg::POINT_W +: cpms_pkg::POINT_W]));
                  error_count++;
               end
            end
         end
         points_checked++;
         if (points_checked % 40 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------

   initial begin
      // state after reset
      cfg_axis    = cpms_pkg::AXIS_Y;
      cfg_max_rad = 31'd65536;
      cfg_hmin    = -32'sd65536;
      cfg_hmax    = 32'sd65536;
      cfg_off_x   = '0;
      cfg_off_y   = '0;
      cfg_off_z   = '0;
      rad         = '0;
      ang         = '0;
      hgt         = '0;
      rad_vel     = '0;
      ang_vel     = '0;
      hgt_vel     = '0;
      last_pt     = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed rows with reset settings: axis y, radius bound 1.0, height +-1.0
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000, 1'b1, pt(0, 0, 0));
      add_row(OP_UNUSED,                     32'hFFFF_FFFF, 1'b1, pt(0, 0, 0));
      add_row(cpms_pkg::OP_SET_RADIUS,       32'h0001_0000, 1'b1, pt(0, 0, 0));
      // angle zero: cos is exactly one, sin zero
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000, 1'b1, pt(Q_ONE, 0, 0));
      // negative radius load clamps to zero
      add_row(cpms_pkg::OP_SET_RADIUS,       32'h8000_0000, 1'b1, pt(Q_ONE, 0, 0));
      add_row(cpms_pkg::OP_TICK,             32'hFFFF_FFFF, 1'b1, pt(0, 0, 0));
      // radius past the bound with the most negative speed
      add_row(cpms_pkg::OP_SET_RADIUS,       32'h7FFF_FFFF);
      add_row(cpms_pkg::OP_SET_RADIUS_SPEED, 32'h8000_0000);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000, 1'b1, pt(Q_ONE, 0, 0));
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000, 1'b1, pt(Q_ONE, 0, 0));
      // sum went negative, bounces at zero
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000, 1'b1, pt(0, 0, 0));
      add_row(cpms_pkg::OP_SET_RADIUS,       32'h0000_8000);
      // quarter turn, upper value bits ignored
      add_row(cpms_pkg::OP_SET_ANGLE,        32'hABCD_4000);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000);
      // height clamp at the top, then at the bottom with saturating speed
      add_row(cpms_pkg::OP_SET_HEIGHT,       32'h7FFF_FFFF);
      add_row(cpms_pkg::OP_SET_HEIGHT_SPEED, 32'h0001_0000);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000);
      add_row(cpms_pkg::OP_SET_HEIGHT,       32'h8000_0000);
      add_row(cpms_pkg::OP_SET_HEIGHT_SPEED, 32'h8000_0000);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000);
      // angle speed of half a turn, then wrap from the top
      add_row(cpms_pkg::OP_SET_ANGLE_SPEED,  32'hFFFF_8000);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000);
      add_row(cpms_pkg::OP_SET_ANGLE,        32'hFFFF_FFFF);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000);
      add_row(cpms_pkg::OP_TICK,             32'h0000_0000);

      foreach (stim_rows[i]) push_request(stim_rows[i].op, stim_rows[i].val,
                                          stim_rows[i].typed, stim_rows[i].want);

      // widest limits, offsets at the rails so point sums saturate
      program_registers(cpms_pkg::AXIS_Z, 31'h7FFF_FFFF, Q_MIN[31:0], Q_MAX[31:0],
                        Q_MAX[31:0], Q_MIN[31:0], Q_MAX[31:0]);
      run_random(100);

      // zero radius bound and inverted height limits
      program_registers(cpms_pkg::AXIS_X, 31'd0, 32'sd65536, -32'sd65536,
                        -32'sd196608, 32'sd327680, 32'd0);
      run_random(100);

      // axis off: point frozen while the state keeps moving
      program_registers(cpms_pkg::AXIS_NONE, 31'd196608, -32'sd131072, 32'sd131072,
                        32'd0, 32'd0, 32'd0);
      run_random(60);

      // random settings around the working range
      for (int p = 0; p < 5; p++) begin
         program_registers(2'($urandom_range(cpms_pkg::AXIS_Y, cpms_pkg::AXIS_X)),
                           31'(($urandom_range(0, 7) == 0) ? $urandom
                                                           : $urandom_range(0, 16 * Q_ONE)),
                           -$urandom_range(0, 8 * Q_ONE), $urandom_range(0, 8 * Q_ONE),
                           draw_offset(), draw_offset(), draw_offset());
         run_random(110);
      end

      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run covered %0d requests (%0d ticks) under %0d csr settings plus reset values",
               requests_sent, ticks_sent, settings_used);
      $display("%0d response points checked, %0d mismatches", points_checked, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("timeout with %0d responses outstanding", pending_points.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
